/* rtl/core/bsfe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stuffing frame encoder package
// Shared constants and the descriptor type that travels from the front end
// to the back end through the command queue.
// ----------------------------------------------------------------------------
package bsfe_pkg;

  // Framing and escape bytes.
  localparam logic [7:0] FLAG_START = 8'h7D;
  localparam logic [7:0] FLAG_END   = 8'h7E;
  localparam logic [7:0] ESC_BYTE   = 8'h7F;

  // Escape codes sent after ESC_BYTE for the three reserved payload values.
  localparam logic [7:0] ESC_CODE_START = 8'h00;
  localparam logic [7:0] ESC_CODE_END   = 8'h01;
  localparam logic [7:0] ESC_CODE_ESC   = 8'h02;

  // Output slot numbers within one descriptor, in stream order.
  localparam logic [1:0] SLOT_START = 2'd0;
  localparam logic [1:0] SLOT_ESC   = 2'd1;
  localparam logic [1:0] SLOT_DATA  = 2'd2;
  localparam logic [1:0] SLOT_END   = 2'd3;

  // One classified input word: which slots it produces and its data byte.
  typedef struct packed {
    logic       has_start;
    logic       has_esc;
    logic [7:0] data_byte;
    logic       has_end;
  } bsfe_desc_t;

endpackage

/* rtl/core/byte_stuffing_frame_encoder_unit.sv */
`timescale 1ns / 1ps
// An accepted byte passes through the command queue and then the output register before
// its first coded word is visible. One coded word per cycle while the consumer pops; a
// byte yields 1 to 4 coded words (2 for an escaped byte inside a frame).
// The command queue holds FifoDepth bytes, so input keeps flowing while output stalls
// until the queue fills.
// Reset (rst_ni low, asynchronous) closes any open frame and empties queue and output.
// ----------------------------------------------------------------------------
// Byte stuffing frame encoder top level
// Front end classifies payload bytes, a command queue decouples it from the
// back end, which emits the stuffed byte stream one word per cycle while popped.
// ----------------------------------------------------------------------------
module byte_stuffing_frame_encoder_unit import bsfe_pkg::*; #(
  parameter int FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] payload_byte_i,
  input  logic       frame_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] coded_byte_o,
  output logic       run_last_o
);

  logic       q_push;
  bsfe_desc_t q_desc;
  logic       q_full;
  logic       q_valid;
  bsfe_desc_t q_head;
  logic       q_pop;

  assign full = q_full;

  // Front end: framing state and byte classification.
  bsfe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .payload_byte_i (payload_byte_i),
    .frame_last_i   (frame_last_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_desc_o       (q_desc)
  );

  // Command queue between the two halves.
  bsfe_cmd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_desc_i (q_desc),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_desc_o (q_head)
  );

  // Back end: slot sequencing and output register.
  bsfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_desc_i  (q_head),
    .head_pop_o   (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .coded_byte_o (coded_byte_o),
    .run_last_o   (run_last_o)
  );

endmodule

/* rtl/core/bsfe_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stuffing frame encoder front end
// Accepts payload words, tracks whether a frame is open and classifies each
// byte into a descriptor for the back end.
// ----------------------------------------------------------------------------
module bsfe_front import bsfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] payload_byte_i,
  input  logic       frame_last_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output bsfe_desc_t q_desc_o
);

  logic frame_open_q;
  logic frame_open_d;

  // A word is taken whenever the queue has room.
  assign q_push_o = push_i && !q_full_i;

  // Classify the byte: reserved values become an escape pair.
  always_comb begin
    q_desc_o.has_start = !frame_open_q;
    q_desc_o.has_end   = frame_last_i;
    q_desc_o.has_esc   = 1'b1;
    case (payload_byte_i)
      FLAG_START: q_desc_o.data_byte = ESC_CODE_START;
      FLAG_END:   q_desc_o.data_byte = ESC_CODE_END;
      ESC_BYTE:   q_desc_o.data_byte = ESC_CODE_ESC;
      default: begin
        q_desc_o.has_esc   = 1'b0;
        q_desc_o.data_byte = payload_byte_i;
      end
    endcase
  end

  // The last byte of a frame closes it; any other byte leaves it open.
  assign frame_open_d = q_push_o ? !frame_last_i : frame_open_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
    end else begin
      frame_open_q <= frame_open_d;
    end
  end

endmodule

/* rtl/core/bsfe_cmd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stuffing frame encoder command queue
// Small register-based FIFO of descriptors between front and back end.
// ----------------------------------------------------------------------------
module bsfe_cmd_fifo import bsfe_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  bsfe_desc_t push_desc_i,
  input  logic       pop_i,
  output logic       full_o,
  output logic       valid_o,
  output bsfe_desc_t head_desc_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  bsfe_desc_t          mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o      = (count_q == DepthCnt);
  assign valid_o     = (count_q != '0);
  assign head_desc_o = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && valid_o;

  // Pointer and fill count updates with explicit wrap.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset; entries are read only after being written.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

/* rtl/core/bsfe_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stuffing frame encoder back end
// Walks the slots of the head descriptor and emits one coded word per cycle
// into an output register that the consumer pops, stalling while it is not popped.
// ----------------------------------------------------------------------------
module bsfe_back import bsfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  bsfe_desc_t head_desc_i,
  output logic       head_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] coded_byte_o,
  output logic       run_last_o
);

  logic [1:0] step_q, step_d;
  logic [3:0] present;
  logic [1:0] slot;
  logic       slot_found;
  logic       slot_final;
  logic [7:0] slot_byte;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       emit;

  assign present = {head_desc_i.has_end, 1'b1, head_desc_i.has_esc, head_desc_i.has_start};

  // Pick the first present slot at or after the current step.
  always_comb begin
    slot       = SLOT_END;
    slot_found = 1'b0;
    for (int s = 0; s < 4; s++) begin
      if (!slot_found && present[s] && (2'(s) >= step_q)) begin
        slot       = 2'(s);
        slot_found = 1'b1;
      end
    end
  end

  // The picked slot is final when no later slot is present.
  always_comb begin
    slot_final = 1'b1;
    for (int s = 0; s < 4; s++) begin
      if (present[s] && (2'(s) > slot)) begin
        slot_final = 1'b0;
      end
    end
  end

  // Byte carried by each slot.
  always_comb begin
    case (slot)
      SLOT_START: slot_byte = FLAG_START;
      SLOT_ESC:   slot_byte = ESC_BYTE;
      SLOT_DATA:  slot_byte = head_desc_i.data_byte;
      SLOT_END:   slot_byte = FLAG_END;
      default:    slot_byte = head_desc_i.data_byte;
    endcase
  end

  // Load the output register when it is free or being drained this cycle.
  assign emit       = head_valid_i && (!out_valid_q || pop_i);
  assign head_pop_o = emit && slot_final;

  always_comb begin
    step_d = step_q;
    if (emit) begin
      step_d = slot_final ? SLOT_START : slot + 2'd1;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= SLOT_START;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= slot_byte;
      out_last_q <= slot_final;
    end
  end

  assign empty_o      = !out_valid_q;
  assign coded_byte_o = out_byte_q;
  assign run_last_o   = out_last_q;

endmodule

/* rtl/core/bsfe_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stuffing frame encoder port checker
// Watches the top-level ports for stream rules and output stability.
// ----------------------------------------------------------------------------
module bsfe_port_checker import bsfe_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] coded_byte_o,
  input logic       run_last_o
);

  // A waiting word that is not taken stays unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(coded_byte_o) && $stable(run_last_o))
    else $error("output word changed while stalled");

  // The end flag only ever closes the words of a byte.
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (coded_byte_o == FLAG_END) |-> run_last_o)
    else $error("end flag not marked as last word");

  // An escape is always followed by its code within the same byte.
  a_esc_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (coded_byte_o == ESC_BYTE) |-> !run_last_o)
    else $error("escape byte marked as last word");

  // A start flag is always followed by the byte's encoding.
  a_start_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (coded_byte_o == FLAG_START) |-> !run_last_o)
    else $error("start flag marked as last word");

endmodule

bind byte_stuffing_frame_encoder_unit bsfe_port_checker u_bsfe_port_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .coded_byte_o (coded_byte_o),
  .run_last_o   (run_last_o)
);

/* tb/bsfe_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stuffing frame encoder checker
// Watches the byte queue and the coded word queue of the encoder, predicts
// the stuffed word stream for every accepted byte, and compares each popped
// word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module bsfe_checker import bsfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_i,
  input  logic [7:0] payload_byte_i,
  input  logic       frame_last_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  logic [7:0] coded_byte_i,
  input  logic       run_last_i,
  output int         err_count_o,
  output int         pending_o
);

  // One coded word as it should leave the encoder.
  typedef struct packed {
    logic [7:0] coded_byte;
    logic       run_last;
  } coded_word_t;

  coded_word_t expected_words[$];
  logic        frame_open;
  int          errors = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    errors++;
  endtask

  // Turns one payload byte into its run of coded words and queues them.
  function automatic void stuff_byte(input logic [7:0] pb, input logic last);
    coded_word_t run[$];
    // A byte that arrives with no frame open starts a new frame.
    if (!frame_open) begin
      run.push_back({FLAG_START, 1'b0});
      frame_open = 1'b1;
    end
    // Reserved values never travel as data; they go out as an escape pair.
    case (pb)
      FLAG_START: begin
        run.push_back({ESC_BYTE, 1'b0});
        run.push_back({ESC_CODE_START, 1'b0});
      end
      FLAG_END: begin
        run.push_back({ESC_BYTE, 1'b0});
        run.push_back({ESC_CODE_END, 1'b0});
      end
      ESC_BYTE: begin
        run.push_back({ESC_BYTE, 1'b0});
        run.push_back({ESC_CODE_ESC, 1'b0});
      end
      default: begin
        run.push_back({pb, 1'b0});
      end
    endcase
    if (last) begin
      run.push_back({FLAG_END, 1'b0});
      frame_open = 1'b0;
    end
    run[run.size() - 1].run_last = 1'b1;
    foreach (run[i]) expected_words.push_back(run[i]);
  endfunction

  // Pops are checked before the same edge's push is predicted, so a word that
  // shows up early can never be matched by a byte accepted at that edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    coded_word_t want;
    if (!rst_ni) begin
      expected_words.delete();
      frame_open = 1'b0;
    end else begin
      if (pop_i && !empty_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("word %02h popped with nothing pending", coded_byte_i));
        end else begin
          want = expected_words.pop_front();
          if (coded_byte_i !== want.coded_byte) begin
            report_mismatch($sformatf("coded_byte is %02h, want %02h",
                                      coded_byte_i, want.coded_byte));
          end
          if (run_last_i !== want.run_last) begin
            report_mismatch($sformatf("run_last is %b, want %b on word %02h",
                                      run_last_i, want.run_last, want.coded_byte));
          end
        end
      end
      if (push_i && !full_i) stuff_byte(payload_byte_i, frame_last_i);
    end
    err_count_o <= errors;
    pending_o   <= expected_words.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stuffing frame encoder testbench
// Sends directed frames covering the reserved byte values and single-byte
// frames, then random frames biased toward the escape range, with random
// gaps on the byte side and random stalls on the word side. The checker
// predicts and compares; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top import bsfe_pkg::*;;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] payload_byte_i = 8'h00;
  logic       frame_last_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] coded_byte_o;
  logic       run_last_o;

  int  err_count;
  int  words_pending;
  int  pop_hold = 0;
  int  bytes_sent = 0;
  // While set, neither side idles.
  bit  calm = 1'b0;

  always #5 clk_i = ~clk_i;

  byte_stuffing_frame_encoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .payload_byte_i(payload_byte_i),
    .frame_last_i  (frame_last_i),
    .empty         (empty),
    .pop           (pop),
    .coded_byte_o  (coded_byte_o),
    .run_last_o    (run_last_o)
  );

  bsfe_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_i        (full),
    .payload_byte_i(payload_byte_i),
    .frame_last_i  (frame_last_i),
    .empty_i       (empty),
    .pop_i         (pop),
    .coded_byte_i  (coded_byte_o),
    .run_last_i    (run_last_o),
    .err_count_o   (err_count),
    .pending_o     (words_pending)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random byte, leaning on the reserved values and their neighbors.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 8'($urandom_range(8'h7C, 8'h80));
    if (r < 35) return (r < 30) ? 8'h00 : 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Word side stalls at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop      <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      pop      <= 1'b1;
      pop_hold <= pick_gap();
    end
  end

  // Offers one byte, after an optional gap, and returns at its acceptance edge.
  task automatic send_byte(input logic [7:0] pb, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push           <= 1'b1;
    payload_byte_i <= pb;
    frame_last_i   <= last;
    do @(posedge clk_i); while (full);
    bytes_sent++;
  endtask

  // Holds the byte side until the encoder has delivered everything.
  task automatic drain_words();
    push <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1);
  endtask

  initial begin
    int len;
    int r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-byte frames: both ends of the range, the reserved values and
    // their neighbors.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(FLAG_START, 1'b1);
    send_byte(FLAG_END, 1'b1);
    send_byte(ESC_BYTE, 1'b1);
    send_byte(8'h7C, 1'b1);
    send_byte(8'h80, 1'b1);
    // Every reserved value inside a longer frame.
    send_byte(FLAG_START, 1'b0);
    send_byte(FLAG_END, 1'b0);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h01, 1'b1);
    // Frame that closes on an escaped byte.
    send_byte(8'h41, 1'b0);
    send_byte(ESC_BYTE, 1'b1);
    // Back-to-back reserved values.
    send_byte(FLAG_END, 1'b0);
    send_byte(FLAG_END, 1'b0);
    send_byte(FLAG_START, 1'b1);
    drain_words();

    // Random frames, mostly short, some long, with calm stretches between.
    while (bytes_sent < 345) begin
      calm = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 6);
      else if (r < 90) len = $urandom_range(7, 16);
      else len = $urandom_range(20, 40);
      send_frame(len);
      if (bytes_sent > 200 && bytes_sent < 215) drain_words();
    end
    calm = 1'b0;

    drain_words();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
